/* hw/rtl/ilp_pkg.sv */
// Shared types, codes and helpers for the integer literal parser.
// Used by ilp_step and integer_literal_parser_core; no dependencies.
package ilp_pkg;

  // longest line that is looked at; later characters are dropped
  localparam int unsigned MaxChars = 63;
  localparam int unsigned CntW     = $clog2(MaxChars + 1);
  localparam int unsigned MagW     = 63;

  // parse phase codes
  localparam logic [2:0] PhStart  = 3'd0;
  localparam logic [2:0] PhSign   = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhPrefix = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;

  // number base codes
  localparam logic [1:0] BaseDec = 2'd0;
  localparam logic [1:0] BaseHex = 2'd1;
  localparam logic [1:0] BaseBin = 2'd2;

  // result status codes
  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StEmpty = 3'd1;
  localparam logic [2:0] StBad   = 3'd2;
  localparam logic [2:0] StOvf   = 3'd3;
  localparam logic [2:0] StZero  = 3'd4;

  // characters of the grammar
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharB     = 8'h62;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
    logic       is_empty;
  } ilp_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic        [2:0]  status;
  } ilp_out_t;

  typedef struct packed {
    logic [2:0]      phase;
    logic [1:0]      number_base;
    logic [MagW-1:0] magnitude;
    logic            negative;
    logic [2:0]      error_code;
    logic [CntW-1:0] char_count;
  } ilp_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } ilp_digit_t;

  localparam ilp_state_t StateReset = '{
    phase:       PhStart,
    number_base: BaseDec,
    magnitude:   '0,
    negative:    1'b0,
    error_code:  StOk,
    char_count:  '0
  };

  // digit value of a character in the given base
  function automatic ilp_digit_t digit_of(logic [7:0] ch, logic [1:0] base);
    ilp_digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d.ok  = 1'b1;
      d.val = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      d.ok  = 1'b1;
      d.val = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      d.ok  = 1'b1;
      d.val = 4'(ch - 8'h37);
    end
    case (base)
      BaseHex: ;
      BaseBin: if (d.val > 4'd1) d.ok = 1'b0;
      default: if (d.val > 4'd9) d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/ilp_step.sv */
// Next-state logic for one character of the line: grammar, digit check,
// accumulate with overflow detection. Depends on ilp_pkg.
module ilp_step (
  input  ilp_pkg::ilp_state_t state_i,
  input  logic [7:0]          char_i,
  input  logic                empty_i,
  output ilp_pkg::ilp_state_t state_o
);
  import ilp_pkg::*;

  ilp_digit_t      dig;
  ilp_digit_t      dec_dig;
  logic [MagW+3:0] prod;
  logic [MagW+3:0] acc;
  logic            take;

  assign dig     = digit_of(char_i, state_i.number_base);
  assign dec_dig = digit_of(char_i, BaseDec);
  assign take    = !empty_i && (state_i.char_count < CntW'(MaxChars));

  // magnitude * base + digit, four spare bits catch overflow
  always_comb begin
    case (state_i.number_base)
      BaseHex: prod = {state_i.magnitude, 4'b0};
      BaseBin: prod = {3'b0, state_i.magnitude, 1'b0};
      default: prod = {1'b0, state_i.magnitude, 3'b0} + {3'b0, state_i.magnitude, 1'b0};
    endcase
    acc = prod + {{MagW{1'b0}}, dig.val};
  end

  always_comb begin
    state_o = state_i;
    if (take) begin
      state_o.char_count = state_i.char_count + CntW'(1);
      if (state_i.error_code == StOk) begin
        unique case (state_i.phase)
          PhStart, PhSign: begin
            if (state_i.phase == PhStart && char_i == CharMinus) begin
              state_o.negative = 1'b1;
              state_o.phase    = PhSign;
            end else if (char_i == CharZero) begin
              state_o.phase = PhZero;
            end else if (!dec_dig.ok) begin
              state_o.error_code = StBad;
            end else begin
              state_o.magnitude = MagW'(dec_dig.val);
              state_o.phase     = PhDigits;
            end
          end
          PhZero: begin
            if (char_i == CharX) begin
              state_o.number_base = BaseHex;
              state_o.phase       = PhPrefix;
            end else if (char_i == CharB) begin
              state_o.number_base = BaseBin;
              state_o.phase       = PhPrefix;
            end else begin
              state_o.error_code = StZero;
            end
          end
          PhPrefix: begin
            if (!dig.ok) begin
              state_o.error_code = StBad;
            end else if (dig.val == 4'd0) begin
              state_o.error_code = StZero;
            end else begin
              state_o.magnitude = MagW'(dig.val);
              state_o.phase     = PhDigits;
            end
          end
          default: begin
            if (!dig.ok) begin
              state_o.error_code = StBad;
            end else if (|acc[MagW+3:MagW]) begin
              state_o.error_code = StOvf;
            end else begin
              state_o.magnitude = acc[MagW-1:0];
            end
          end
        endcase
      end
    end
  end

endmodule

/* hw/rtl/integer_literal_parser_core.sv */
// Integer literal parser: ASCII characters in, one signed value and status
// per line out. Depends on ilp_pkg and ilp_step.
//
// Usage: each input transfer carries one character (char_code), or none when
// is_empty is set; end_of_line marks the transfer that closes the line. A
// line may be "-", "0x"/"0b" prefixed or plain decimal. Only the first
// MaxChars characters of a line are looked at.
// Each line gives exactly one output transfer with value and status
// (ok, empty line, bad digit, overflow, leading zero or incomplete prefix);
// value is zero unless the status is ok.
// Path: the closing item is held in the input register, then its result is
// registered in the output register, where out_valid_o rises. Throughput:
// one character per cycle while no line end waits on the output; the
// per-character work is one pass through ilp_step between the input
// register and the parse state registers.
// Reset: clears the parse state and both valid flags; the next character
// starts a new line.
// Stall: while a result waits in the output register, characters that do
// not end a line keep flowing; the item that ends the next line waits in
// the input register and in_ready_o drops until the output is taken.
module integer_literal_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ilp_pkg::ilp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ilp_pkg::ilp_out_t out_data_o
);
  import ilp_pkg::*;

  ilp_in_t         in_q;
  logic            in_valid_q;
  ilp_state_t      state_q, state_d;
  ilp_state_t      step_state;
  logic            out_valid_q;
  logic [MagW-1:0] res_mag_q, res_mag_d;
  logic            res_neg_q, res_neg_d;
  logic [2:0]      res_status_q, res_status_d;
  logic            out_free;
  logic            process;
  logic [63:0]     mag_ext;

  assign out_free   = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && (!in_q.end_of_line || out_free);
  assign in_ready_o = !in_valid_q || process;

  ilp_step u_step (
    .state_i (state_q),
    .char_i  (in_q.char_code),
    .empty_i (in_q.is_empty),
    .state_o (step_state)
  );

  // line close: pick the status from the state after the last character
  always_comb begin
    res_mag_d = '0;
    res_neg_d = 1'b0;
    if (step_state.error_code != StOk) begin
      res_status_d = step_state.error_code;
    end else if (step_state.char_count == '0) begin
      res_status_d = StEmpty;
    end else if (step_state.phase == PhSign || step_state.phase == PhPrefix) begin
      res_status_d = StZero;
    end else begin
      res_status_d = StOk;
      if (step_state.phase == PhDigits) begin
        res_mag_d = step_state.magnitude;
        res_neg_d = step_state.negative;
      end
    end
    state_d = in_q.end_of_line ? StateReset : step_state;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (process) begin
        in_valid_q <= 1'b0;
      end
      if (process) begin
        state_q <= state_d;
      end
      if (process && in_q.end_of_line) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (process && in_q.end_of_line) begin
      res_mag_q    <= res_mag_d;
      res_neg_q    <= res_neg_d;
      res_status_q <= res_status_d;
    end
  end

  // sign applied on the way out
  assign mag_ext           = {1'b0, res_mag_q};
  assign out_valid_o       = out_valid_q;
  assign out_data_o.value  = res_neg_q ? (64'd0 - mag_ext) : mag_ext;
  assign out_data_o.status = res_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.char_count <= CntW'(MaxChars))
    else $error("character count past line limit");

  a_clear_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && in_q.end_of_line |=> state_q == StateReset)
    else $error("parse state not cleared after line end");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && !in_q.end_of_line && state_q.error_code != StOk
    |=> state_q.error_code == $past(state_q.error_code))
    else $error("first error overwritten");

  a_value_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |-> out_data_o.value == 64'd0)
    else $error("nonzero value with error status");

  a_no_drop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_status_q))
    else $error("pending result lost");

endmodule
